// ----- rtl/core/imusd_pkg.sv -----
// Shared types and constants for the IMU stillness detector.
`default_nettype none

package imusd_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_THRESHOLD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_TOLERANCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ONE_G           = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STILL_NEEDED    = 2'd3;

  // Register values after reset.
  localparam logic [11:0] GYRO_THRESHOLD_RST  = 12'd96;
  localparam logic [11:0] ACCEL_TOLERANCE_RST = 12'd376;
  localparam logic [13:0] ONE_G_RST           = 14'd4096;
  localparam logic [7:0]  STILL_NEEDED_RST    = 8'd35;

  // Calibration accumulator and sample counter widths.
  localparam int SUM_W = 24;
  localparam int CNT_W = 8;

  // One IMU sample.
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic               accel_ok;
    logic               rate_ok;
    logic               mag_ok;
  } imusd_in_t;

  // One result.
  typedef struct packed {
    logic               calibrating;
    logic               accepted;
    logic               still_now;
    logic               rest_active;
    logic [7:0]         still_run;
    logic signed [15:0] fixed_rate_x;
    logic signed [15:0] fixed_rate_y;
    logic signed [15:0] fixed_rate_z;
  } imusd_out_t;

  // Limits derived from the configuration registers, compared as squares.
  typedef struct packed {
    logic [23:0] thr_sq;
    logic [29:0] hi_sq;
    logic [27:0] lo_sq;
    logic        lo_void;
    logic [7:0]  still_needed;
  } imusd_limits_t;

endpackage

`default_nettype wire

// ----- rtl/core/imu_stillness_detector.sv -----
// IMU stillness detector: gyroscope bias calibration and rest detection.
//
// Input samples arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a transfer happens on a rising edge where
// valid is high and stall is low. Every accepted sample yields exactly one
// result, in order. The datapath is five register stages deep, and one
// sample per cycle is sustained for as long as the receiver does not
// stall.
// The first CAL_SAMPLES samples with a valid rate are summed; the rounded
// per-axis bias is registered from the sums, in time for the next sample.
// The user must write configuration through cfg_write/cfg_index/cfg_data
// only while no sample is in flight; the block does not enforce this.
// Reset (rst, synchronous) empties the pipeline, restarts calibration and
// restores the register defaults; in_stall is held high during reset.
// When the receiver stalls, each stage keeps filling until it holds a
// sample, so the input keeps taking transfers until all stages are full.
`default_nettype none

module imu_stillness_detector
  import imusd_pkg::*;
#(
  parameter int CAL_SAMPLES = 200
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire imusd_in_t              in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output imusd_out_t                  out_data,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [CNT_W-1:0] CAL_TARGET = CNT_W'(CAL_SAMPLES);

  function automatic logic [31:0] square16(input logic signed [15:0] v);
    logic signed [31:0] p;
    p = 32'(v) * 32'(v);
    return unsigned'(p);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  imusd_limits_t limits;

  // Calibration and detection state.
  logic signed [SUM_W-1:0] cal_sum_x, cal_sum_y, cal_sum_z;
  logic [CNT_W-1:0]        cal_seen;
  logic signed [15:0]      bias_x, bias_y, bias_z;
  logic [7:0]              still_counter, still_counter_next;
  logic                    rest_flag, rest_flag_next;
  logic                    mag_seen;

  // Stage registers.
  logic               s0_valid;
  imusd_in_t          s0_data;
  logic               s1_valid, s1_cal, s1_rate_ok, s1_accepted;
  logic signed [15:0] s1_rate_x, s1_rate_y, s1_rate_z;
  logic [31:0]        s1_a2;
  logic               s2_valid, s2_cal, s2_accepted, s2_acc_ok;
  logic signed [15:0] s2_fix_x, s2_fix_y, s2_fix_z;
  logic               s3_valid, s3_cal, s3_accepted, s3_acc_ok;
  logic signed [15:0] s3_fix_x, s3_fix_y, s3_fix_z;
  logic [31:0]        s3_g2;

  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic s0_cal, s1_acc_ok_next, s3_still;
  logic signed [15:0] fix_x_next, fix_y_next, fix_z_next;
  logic [8:0] cnt_inc;

  imusd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  imusd_bias_div #(.N(CAL_SAMPLES)) u_bias_x (.clk(clk), .sum(cal_sum_x), .bias(bias_x));
  imusd_bias_div #(.N(CAL_SAMPLES)) u_bias_y (.clk(clk), .sum(cal_sum_y), .bias(bias_y));
  imusd_bias_div #(.N(CAL_SAMPLES)) u_bias_z (.clk(clk), .sum(cal_sum_z), .bias(bias_z));

  // Each stage loads when it is empty or its content moves on.
  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign rdy0     = !s0_valid || rdy1;
  assign in_stall = rst || !rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0) s0_valid  <= in_valid;
      if (rdy1) s1_valid  <= s0_valid;
      if (rdy2) s2_valid  <= s1_valid;
      if (rdy3) s3_valid  <= s2_valid;
      if (rdy4) out_valid <= s3_valid;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_data <= in_data;
    end
  end

  // Stage 1: calibration bookkeeping, acceptance test, acceleration square.
  assign s0_cal = (cal_seen < CAL_TARGET);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_sum_x <= '0;
      cal_sum_y <= '0;
      cal_sum_z <= '0;
      cal_seen  <= '0;
      mag_seen  <= 1'b0;
    end else if (s0_valid && rdy1) begin
      if (s0_cal && s0_data.rate_ok) begin
        cal_sum_x <= cal_sum_x + SUM_W'(s0_data.rate_x);
        cal_sum_y <= cal_sum_y + SUM_W'(s0_data.rate_y);
        cal_sum_z <= cal_sum_z + SUM_W'(s0_data.rate_z);
        cal_seen  <= cal_seen + CNT_W'(1);
      end
      if (!s0_cal && s0_data.mag_ok) begin
        mag_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_cal      <= s0_cal;
      s1_rate_ok  <= !s0_cal && s0_data.rate_ok;
      s1_accepted <= !s0_cal && s0_data.accel_ok && s0_data.rate_ok
                     && (mag_seen || s0_data.mag_ok);
      s1_rate_x   <= s0_data.rate_x;
      s1_rate_y   <= s0_data.rate_y;
      s1_rate_z   <= s0_data.rate_z;
      s1_a2       <= square16(s0_data.accel_x) + square16(s0_data.accel_y)
                     + square16(s0_data.accel_z);
    end
  end

  // Stage 2: bias removal with saturation, acceleration band test.
  always_comb begin
    fix_x_next = '0;
    fix_y_next = '0;
    fix_z_next = '0;
    if (s1_rate_ok) begin
      fix_x_next = sat16(17'(s1_rate_x) - 17'(bias_x));
      fix_y_next = sat16(17'(s1_rate_y) - 17'(bias_y));
      fix_z_next = sat16(17'(s1_rate_z) - 17'(bias_z));
    end
    s1_acc_ok_next = (limits.lo_void || (s1_a2 > 32'(limits.lo_sq)))
                     && (s1_a2 < 32'(limits.hi_sq));
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_cal      <= s1_cal;
      s2_accepted <= s1_accepted;
      s2_acc_ok   <= s1_acc_ok_next;
      s2_fix_x    <= fix_x_next;
      s2_fix_y    <= fix_y_next;
      s2_fix_z    <= fix_z_next;
    end
  end

  // Stage 3: squared rotation magnitude.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_cal      <= s2_cal;
      s3_accepted <= s2_accepted;
      s3_acc_ok   <= s2_acc_ok;
      s3_fix_x    <= s2_fix_x;
      s3_fix_y    <= s2_fix_y;
      s3_fix_z    <= s2_fix_z;
      s3_g2       <= square16(s2_fix_x) + square16(s2_fix_y) + square16(s2_fix_z);
    end
  end

  // Stage 4: stillness decision and the saturating still counter.
  always_comb begin
    s3_still           = s3_accepted && s3_acc_ok && (s3_g2 < 32'(limits.thr_sq));
    cnt_inc            = {1'b0, still_counter} + 9'd1;
    still_counter_next = still_counter;
    rest_flag_next     = rest_flag;
    if (s3_accepted) begin
      if (s3_still) begin
        still_counter_next = (cnt_inc < {1'b0, limits.still_needed})
                             ? cnt_inc[7:0] : limits.still_needed;
      end else begin
        still_counter_next = '0;
      end
      rest_flag_next = (still_counter_next >= limits.still_needed);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      still_counter <= '0;
      rest_flag     <= 1'b0;
    end else if (s3_valid && rdy4) begin
      still_counter <= still_counter_next;
      rest_flag     <= rest_flag_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_data.calibrating  <= s3_cal;
      out_data.accepted     <= s3_accepted;
      out_data.still_now    <= s3_still;
      out_data.rest_active  <= rest_flag_next;
      out_data.still_run    <= still_counter_next;
      out_data.fixed_rate_x <= s3_fix_x;
      out_data.fixed_rate_y <= s3_fix_y;
      out_data.fixed_rate_z <= s3_fix_z;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/imusd_cfg.sv -----
// Configuration registers and the squared limits derived from them.
`default_nettype none

module imusd_cfg
  import imusd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output imusd_limits_t               limits
);

  logic [11:0] gyro_threshold;
  logic [11:0] accel_tolerance;
  logic [13:0] one_g;
  logic [7:0]  still_needed;

  logic [14:0] hi_bound;
  logic [13:0] lo_bound;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_threshold  <= GYRO_THRESHOLD_RST;
      accel_tolerance <= ACCEL_TOLERANCE_RST;
      one_g           <= ONE_G_RST;
      still_needed    <= STILL_NEEDED_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GYRO_THRESHOLD:  gyro_threshold  <= cfg_data[11:0];
        CFG_ACCEL_TOLERANCE: accel_tolerance <= cfg_data[11:0];
        CFG_ONE_G:           one_g           <= cfg_data;
        CFG_STILL_NEEDED:    still_needed    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Band edges around one g; the lower edge drops out when it would go negative.
  assign hi_bound = {1'b0, one_g} + {3'b000, accel_tolerance};
  assign lo_bound = one_g - {2'b00, accel_tolerance};

  // Squared limits are registered so the compare paths start from flops.
  always_ff @(posedge clk) begin
    limits.thr_sq       <= 24'(gyro_threshold) * 24'(gyro_threshold);
    limits.hi_sq        <= 30'(hi_bound) * 30'(hi_bound);
    limits.lo_sq        <= 28'(lo_bound) * 28'(lo_bound);
    limits.lo_void      <= (one_g < {2'b00, accel_tolerance});
    limits.still_needed <= still_needed;
  end

endmodule

`default_nettype wire

// ----- rtl/core/imusd_bias_div.sv -----
// Rounded division of one calibration sum by the sample count, registered.
`default_nettype none

module imusd_bias_div
  import imusd_pkg::*;
#(
  parameter int N = 200
) (
  input  wire logic                    clk,
  input  wire logic signed [SUM_W-1:0] sum,
  output logic signed [15:0]           bias
);

  // Reciprocal with a 31 bit shift is exact for magnitudes below 2^23.
  localparam int          SHIFT = 31;
  localparam logic [31:0] RECIP = 32'(((64'd1 << SHIFT) + 64'(N) - 64'd1) / 64'(N));
  localparam logic [SUM_W-1:0] HALF = SUM_W'(N / 2);

  logic             neg;
  logic [SUM_W-1:0] abs_sum;
  logic [SUM_W-1:0] mag;
  logic [55:0]      prod;
  logic [16:0]      quot;
  logic [16:0]      signed_quot;

  // Round half away from zero: divide the magnitude, then restore the sign.
  always_comb begin
    neg         = sum[SUM_W-1];
    abs_sum     = neg ? SUM_W'(-sum) : SUM_W'(sum);
    mag         = abs_sum + HALF;
    prod        = 56'(mag) * 56'(RECIP);
    quot        = prod[SHIFT +: 17];
    signed_quot = neg ? 17'(-quot) : quot;
  end

  always_ff @(posedge clk) begin
    bias <= signed_quot[15:0];
  end

endmodule

`default_nettype wire
